### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms; each expects clock and reset in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// antecedent implies consequent at the same edge
`define ASSERT_IMPLY(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

`endif

### hdl/tpp_pkg.sv
// ----------------------------------------------------------------------------
// tpp_pkg
// Types and constants of the turtle pen plotter grid unit.
// ----------------------------------------------------------------------------
package tpp_pkg;

   localparam int GRID_SIZE_DEFAULT = 64;

   localparam int MODE_W      = 3;
   localparam int STEPS_W     = 6;
   localparam int ROW_INDEX_W = 6;
   localparam int ROW_BITS_W  = 64;

   localparam int CMD_DEPTH   = 2;
   localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);

   localparam int RSP_DEPTH   = 4;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W   = $clog2(RSP_DEPTH + 1);

   typedef enum logic [MODE_W-1:0] {
      MODE_PEN_UP   = 3'd0,
      MODE_PEN_DOWN = 3'd1,
      MODE_RIGHT    = 3'd2,
      MODE_LEFT     = 3'd3,
      MODE_FORWARD  = 3'd4,
      MODE_PRINT    = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      HEAD_UP    = 2'd0,
      HEAD_RIGHT = 2'd1,
      HEAD_DOWN  = 2'd2,
      HEAD_LEFT  = 2'd3
   } heading_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_WALK  = 2'd1,
      ST_MARK  = 2'd2,
      ST_PRINT = 2'd3
   } state_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [STEPS_W-1:0] steps;
   } req_type;

   typedef struct packed {
      logic [ROW_INDEX_W-1:0] row_index;
      logic [ROW_BITS_W-1:0]  row_bits;
      logic                   last;
   } rsp_type;

   typedef struct packed {
      mode_type           kind;
      logic [STEPS_W-1:0] steps;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_if_type;

   typedef struct packed {
      logic    push;
      rsp_type data;
   } rsp_push_type;

endpackage

### hdl/tpp_ram.sv
// ----------------------------------------------------------------------------
// tpp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tpp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/tpp_front.sv
// ----------------------------------------------------------------------------
// tpp_front
// Command intake: decode each transfer, drop no-op commands, queue the rest.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  tpp_pkg::req_type    req_data,
   output tpp_pkg::cmd_if_type cmd_if,
   input  logic                cmd_pop
);

   tpp_pkg::cmd_type                   entries_ff [tpp_pkg::CMD_DEPTH];
   logic [tpp_pkg::CMD_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [tpp_pkg::CMD_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [tpp_pkg::CMD_CNT_W-1:0]      count_ff, count_in;
   logic                               accept;
   logic                               keep;
   logic                               enq;
   tpp_pkg::cmd_type                   cmd_new;

   assign full   = (count_ff == tpp_pkg::CMD_CNT_W'(tpp_pkg::CMD_DEPTH));
   assign accept = push && !full;

   always_comb begin
      cmd_new.kind  = tpp_pkg::mode_type'(req_data.mode);
      cmd_new.steps = req_data.steps;
      case (tpp_pkg::mode_type'(req_data.mode))
         tpp_pkg::MODE_PEN_UP,
         tpp_pkg::MODE_PEN_DOWN,
         tpp_pkg::MODE_RIGHT,
         tpp_pkg::MODE_LEFT,
         tpp_pkg::MODE_PRINT:   keep = 1'b1;
         tpp_pkg::MODE_FORWARD: keep = (req_data.steps != '0);
         default:               keep = 1'b0;
      endcase
   end

   assign enq = accept && keep;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (enq) begin
         wr_ptr_in = (wr_ptr_ff == tpp_pkg::CMD_PTR_W'(tpp_pkg::CMD_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == tpp_pkg::CMD_PTR_W'(tpp_pkg::CMD_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (enq && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!enq && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (enq) begin
         entries_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign cmd_if.valid = (count_ff != '0);
   assign cmd_if.cmd   = entries_ff[rd_ptr_ff];

   `ASSERT_IMPLY(cmd_pop_needs_entry, cmd_pop, count_ff != '0, "command pop from empty queue")

endmodule

### hdl/tpp_back.sv
// ----------------------------------------------------------------------------
// tpp_back
// Command executor: pen state and heading, forward walk with row marking, grid print.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpp_back #(
   parameter int GRID_SIZE = tpp_pkg::GRID_SIZE_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tpp_pkg::cmd_if_type           cmd_if,
   output logic                          cmd_pop,
   output tpp_pkg::rsp_push_type         rsp_push,
   input  logic [tpp_pkg::RSP_CNT_W-1:0] rsp_count
);

   localparam int RW = $clog2(GRID_SIZE);
   localparam logic [RW-1:0] EDGE = RW'(GRID_SIZE - 1);

   tpp_pkg::state_type        state_ff, state_in;
   logic [RW-1:0]             pen_row_ff, pen_row_in;
   logic [RW-1:0]             pen_col_ff, pen_col_in;
   tpp_pkg::heading_type      heading_ff, heading_in;
   logic                      pen_down_ff, pen_down_in;
   logic [tpp_pkg::STEPS_W-1:0] steps_ff, steps_in;
   logic [RW-1:0]             prow_ff, prow_in;
   logic [GRID_SIZE-1:0]      row_valid_ff, row_valid_in;
   logic                      rd_pend_ff, rd_pend_in;
   logic [RW-1:0]             rd_row_ff, rd_row_in;
   logic                      rd_last_ff, rd_last_in;
   logic                      rd_hit_ff, rd_hit_in;

   logic                      ram_wr_en;
   logic [GRID_SIZE-1:0]      ram_wr_data;
   logic                      ram_rd_en;
   logic [RW-1:0]             ram_rd_addr;
   logic [GRID_SIZE-1:0]      ram_rd_data;
   logic [GRID_SIZE-1:0]      old_row;

   logic                      last_step;
   logic                      print_go;
   logic                      print_issue;
   logic                      do_step;
   logic [RW-1:0]             row_adv;
   logic [RW-1:0]             col_adv;

   assign last_step = (steps_ff == tpp_pkg::STEPS_W'(1));
   assign print_go  = ((32'(rsp_count) + 32'(rd_pend_ff)) < 32'(tpp_pkg::RSP_DEPTH - 1));
   assign old_row   = rd_hit_ff ? ram_rd_data : '0;

   always_comb begin
      row_adv = pen_row_ff;
      col_adv = pen_col_ff;
      case (heading_ff)
         tpp_pkg::HEAD_UP: begin
            if (pen_row_ff != '0) row_adv = pen_row_ff - 1'b1;
         end
         tpp_pkg::HEAD_RIGHT: begin
            if (pen_col_ff != EDGE) col_adv = pen_col_ff + 1'b1;
         end
         tpp_pkg::HEAD_DOWN: begin
            if (pen_row_ff != EDGE) row_adv = pen_row_ff + 1'b1;
         end
         default: begin
            if (pen_col_ff != '0) col_adv = pen_col_ff - 1'b1;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tpp_pkg::ST_IDLE: begin
            if (cmd_if.valid) begin
               case (cmd_if.cmd.kind)
                  tpp_pkg::MODE_FORWARD: state_in = tpp_pkg::ST_WALK;
                  tpp_pkg::MODE_PRINT:   state_in = tpp_pkg::ST_PRINT;
                  default:               state_in = tpp_pkg::ST_IDLE;
               endcase
            end
         end
         tpp_pkg::ST_WALK: begin
            if (pen_down_ff) begin
               state_in = tpp_pkg::ST_MARK;
            end else if (last_step) begin
               state_in = tpp_pkg::ST_IDLE;
            end
         end
         tpp_pkg::ST_MARK: begin
            state_in = last_step ? tpp_pkg::ST_IDLE : tpp_pkg::ST_WALK;
         end
         tpp_pkg::ST_PRINT: begin
            if (print_go && prow_ff == EDGE) state_in = tpp_pkg::ST_IDLE;
         end
         default: state_in = tpp_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_pop     = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = pen_row_ff;
      ram_wr_en   = 1'b0;
      do_step     = 1'b0;
      print_issue = 1'b0;
      case (state_ff)
         tpp_pkg::ST_IDLE: begin
            cmd_pop = cmd_if.valid;
         end
         tpp_pkg::ST_WALK: begin
            ram_rd_en = pen_down_ff;
            do_step   = !pen_down_ff;
         end
         tpp_pkg::ST_MARK: begin
            ram_wr_en = 1'b1;
            do_step   = 1'b1;
         end
         tpp_pkg::ST_PRINT: begin
            print_issue = print_go;
            ram_rd_en   = print_go;
            ram_rd_addr = prow_ff;
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   assign ram_wr_data = old_row | (GRID_SIZE'(1) << pen_col_ff);

   // datapath
   always_comb begin
      pen_row_in   = pen_row_ff;
      pen_col_in   = pen_col_ff;
      heading_in   = heading_ff;
      pen_down_in  = pen_down_ff;
      steps_in     = steps_ff;
      prow_in      = prow_ff;
      row_valid_in = row_valid_ff;
      if (cmd_pop) begin
         case (cmd_if.cmd.kind)
            tpp_pkg::MODE_PEN_UP:   pen_down_in = 1'b0;
            tpp_pkg::MODE_PEN_DOWN: pen_down_in = 1'b1;
            tpp_pkg::MODE_RIGHT:    heading_in  = tpp_pkg::heading_type'(heading_ff + 2'd1);
            tpp_pkg::MODE_LEFT:     heading_in  = tpp_pkg::heading_type'(heading_ff - 2'd1);
            tpp_pkg::MODE_FORWARD:  steps_in    = cmd_if.cmd.steps;
            tpp_pkg::MODE_PRINT:    prow_in     = '0;
            default:                steps_in    = steps_ff;
         endcase
      end
      if (do_step) begin
         pen_row_in = row_adv;
         pen_col_in = col_adv;
         steps_in   = steps_ff - 1'b1;
      end
      if (ram_wr_en) begin
         row_valid_in[pen_row_ff] = 1'b1;
      end
      if (print_issue) begin
         prow_in = prow_ff + 1'b1;
      end
      rd_pend_in = print_issue;
      rd_row_in  = prow_ff;
      rd_last_in = (prow_ff == EDGE);
      rd_hit_in  = ram_rd_en ? row_valid_ff[ram_rd_addr] : rd_hit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpp_pkg::ST_IDLE;
         pen_row_ff   <= '0;
         pen_col_ff   <= '0;
         heading_ff   <= tpp_pkg::HEAD_RIGHT;
         pen_down_ff  <= 1'b0;
         row_valid_ff <= '0;
         rd_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pen_row_ff   <= pen_row_in;
         pen_col_ff   <= pen_col_in;
         heading_ff   <= heading_in;
         pen_down_ff  <= pen_down_in;
         row_valid_ff <= row_valid_in;
         rd_pend_ff   <= rd_pend_in;
      end
      steps_ff   <= steps_in;
      prow_ff    <= prow_in;
      rd_row_ff  <= rd_row_in;
      rd_last_ff <= rd_last_in;
      rd_hit_ff  <= rd_hit_in;
   end

   tpp_ram #(
      .WIDTH (GRID_SIZE),
      .DEPTH (GRID_SIZE)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pen_row_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_push.push           = rd_pend_ff;
   assign rsp_push.data.row_index = tpp_pkg::ROW_INDEX_W'(rd_row_ff);
   assign rsp_push.data.row_bits  = tpp_pkg::ROW_BITS_W'(old_row);
   assign rsp_push.data.last      = rd_last_ff;

   `ASSERT_IMPLY(mark_follows_walk, state_ff == tpp_pkg::ST_MARK,
                 $past(state_ff) == tpp_pkg::ST_WALK, "mark without preceding row read")
   `ASSERT_ALWAYS(pen_inside_grid, pen_row_ff <= EDGE && pen_col_ff <= EDGE,
                  "pen position outside grid")

endmodule

### hdl/tpp_rsp_queue.sv
// ----------------------------------------------------------------------------
// tpp_rsp_queue
// Result queue: holds printed rows until the consumer takes them.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpp_rsp_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  tpp_pkg::rsp_push_type         rsp_push,
   output logic [tpp_pkg::RSP_CNT_W-1:0] rsp_count,
   output logic                          empty,
   input  logic                          pop,
   output tpp_pkg::rsp_type              rsp_data
);

   tpp_pkg::rsp_type              entries_ff [tpp_pkg::RSP_DEPTH];
   logic [tpp_pkg::RSP_PTR_W-1:0] wr_ptr_ff;
   logic [tpp_pkg::RSP_PTR_W-1:0] rd_ptr_ff;
   logic [tpp_pkg::RSP_CNT_W-1:0] count_ff, count_in;
   logic                          deq;

   assign empty = (count_ff == '0);
   assign deq   = pop && !empty;

   always_comb begin
      count_in = count_ff;
      if (rsp_push.push && !deq) begin
         count_in = count_ff + 1'b1;
      end else if (!rsp_push.push && deq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (rsp_push.push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (deq)           rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
      if (rsp_push.push) begin
         entries_ff[wr_ptr_ff] <= rsp_push.data;
      end
   end

   assign rsp_count = count_ff;
   assign rsp_data  = entries_ff[rd_ptr_ff];

   `ASSERT_IMPLY(push_has_room, rsp_push.push,
                 count_ff < tpp_pkg::RSP_CNT_W'(tpp_pkg::RSP_DEPTH), "result queue overflow")

endmodule

### hdl/turtle_pen_plotter_grid_unit.sv
// ----------------------------------------------------------------------------
// turtle_pen_plotter_grid_unit
// Turtle plotter on a square bit grid: pen, turn, forward and print commands.
// ----------------------------------------------------------------------------
// Pen and turn: applied when the executor takes them; forward n: n steps, each
//   in WALK pen up, or pen down a row read in WALK then a row write in MARK.
// Print: after the executor takes it, GRID_SIZE rows are read in order through
//   the RAM read port, one per cycle while the result queue has room.
// Reset (synchronous): pen at row 0 column 0, facing right, pen up; per-row
//   valid flags clear the grid at once, no clearing pass.
module turtle_pen_plotter_grid_unit #(
   parameter int GRID_SIZE = tpp_pkg::GRID_SIZE_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  tpp_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output tpp_pkg::rsp_type rsp_data
);

   tpp_pkg::cmd_if_type           cmd_if;
   logic                          cmd_pop;
   tpp_pkg::rsp_push_type         rsp_push;
   logic [tpp_pkg::RSP_CNT_W-1:0] rsp_count;

   tpp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .cmd_if   (cmd_if),
      .cmd_pop  (cmd_pop)
   );

   tpp_back #(
      .GRID_SIZE (GRID_SIZE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_if    (cmd_if),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp_count (rsp_count)
   );

   tpp_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .rsp_push  (rsp_push),
      .rsp_count (rsp_count),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule
